### design/pcdt_pkg.sv
// Shared types and constants for the point cloud decimate and transform core.
package pcdt_pkg;

  // Largest cloud the kept-point counter tracks before it saturates.
  localparam int unsigned MaxCloudPoints = 1048576;
  localparam int unsigned CountFieldMax  = 2097151;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned RowW    = 3 * CoefW;
  localparam int unsigned CountW  = 21;
  localparam int unsigned PhaseW  = 6;
  localparam int unsigned FactorW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FracBits = 14;
  localparam int unsigned ProdW   = CoefW + CoordW;
  localparam int unsigned AccW    = ProdW + 2;
  localparam int unsigned QuotW   = AccW - FracBits;

  localparam logic [CountW-1:0] KeptCap =
      CountW'((MaxCloudPoints < CountFieldMax) ? MaxCloudPoints : CountFieldMax);

  localparam logic [FactorW-1:0] FactorMin = FactorW'(1);
  localparam logic [FactorW-1:0] FactorMax = FactorW'(64);

  localparam logic [RowW-1:0]    RotRow0Reset  = RowW'(48'h0000_0000_4000);
  localparam logic [RowW-1:0]    RotRow1Reset  = RowW'(48'h0000_4000_0000);
  localparam logic [RowW-1:0]    RotRow2Reset  = RowW'(48'h4000_0000_0000);
  localparam logic [FactorW-1:0] KeepEveryReset = FactorW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CfgRotRow0   = 3'd0,
    CfgRotRow1   = 3'd1,
    CfgRotRow2   = 3'd2,
    CfgShiftX    = 3'd3,
    CfgShiftY    = 3'd4,
    CfgShiftZ    = 3'd5,
    CfgKeepEvery = 3'd6
  } cfg_reg_e;

  // Side information that travels with a word down the pipeline.
  typedef struct packed {
    logic              present;
    logic              last;
    logic [CountW-1:0] count;
  } word_ctl_t;

endpackage

### design/point_cloud_decimate_transform_core.sv
// Point cloud decimator with rigid transform R*p+T, rounded and saturated to Q16.16.
// Pipeline: input, product, sum and output registers from input accept to output valid.
// Throughput: one point per cycle unless out_ready_i stalls the pipeline; a point that is
// dropped and does not end a cloud yields no output word and uses no pipeline slot.
// Reset: identity rotation, zero translation, keep factor 4, both counters cleared,
// pipeline empty.
module point_cloud_decimate_transform_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pcdt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pcdt_pkg::RowW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [pcdt_pkg::CoordW-1:0] in_x_i,
  input  logic signed [pcdt_pkg::CoordW-1:0] in_y_i,
  input  logic signed [pcdt_pkg::CoordW-1:0] in_z_i,
  input  logic                              is_finite_i,
  input  logic                              last_of_cloud_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pcdt_pkg::CoordW-1:0] out_x_o,
  output logic signed [pcdt_pkg::CoordW-1:0] out_y_o,
  output logic signed [pcdt_pkg::CoordW-1:0] out_z_o,
  output logic                              point_present_o,
  output logic                              end_of_cloud_o,
  output logic [pcdt_pkg::CountW-1:0]       points_in_cloud_o
);
  import pcdt_pkg::*;

  // Configuration
  logic [RowW-1:0]          rot_q [3];
  logic signed [CoordW-1:0] shift_q [3];
  logic [FactorW-1:0]       keep_q;

  // Decimation state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CountW-1:0] kept_q, kept_d;

  // Pipeline
  logic                     v1_q, v2_q, v3_q, v4_q;
  logic                     rdy1, rdy2, rdy3, rdy4;
  logic signed [CoordW-1:0] pt_q [3];
  word_ctl_t                ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl1_d;
  logic signed [ProdW-1:0]  prod_q [3][3];
  logic signed [AccW-1:0]   acc_q [3];
  logic signed [CoordW-1:0] res_q [3];
  logic signed [CoordW-1:0] res_d [3];

  logic                in_fire;
  logic                keep_pt;
  logic                emit;
  logic [FactorW-1:0]  factor;
  logic [FactorW-1:0]  phase_inc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= RotRow0Reset;
      rot_q[1]   <= RotRow1Reset;
      rot_q[2]   <= RotRow2Reset;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
      keep_q     <= KeepEveryReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgRotRow0:   rot_q[0]   <= cfg_data_i;
        CfgRotRow1:   rot_q[1]   <= cfg_data_i;
        CfgRotRow2:   rot_q[2]   <= cfg_data_i;
        CfgShiftX:    shift_q[0] <= cfg_data_i[CoordW-1:0];
        CfgShiftY:    shift_q[1] <= cfg_data_i[CoordW-1:0];
        CfgShiftZ:    shift_q[2] <= cfg_data_i[CoordW-1:0];
        CfgKeepEvery: keep_q     <= cfg_data_i[FactorW-1:0];
        default: ;
      endcase
    end
  end

  // Ready ripples back from the output register
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_fire    = in_valid_i && rdy1;

  always_comb begin
    if (keep_q < FactorMin) begin
      factor = FactorMin;
    end else if (keep_q > FactorMax) begin
      factor = FactorMax;
    end else begin
      factor = keep_q;
    end
    phase_inc = {1'b0, phase_q} + FactorW'(1);
    keep_pt   = (phase_q == '0) && is_finite_i;
    emit      = keep_pt || last_of_cloud_i;

    kept_d = kept_q;
    if (keep_pt && (kept_q < KeptCap)) begin
      kept_d = kept_q + CountW'(1);
    end
    phase_d = (phase_inc >= factor) ? '0 : phase_inc[PhaseW-1:0];

    ctl1_d.present = keep_pt;
    ctl1_d.last    = last_of_cloud_i;
    ctl1_d.count   = last_of_cloud_i ? kept_d : '0;

    // Close the cloud: restart both counters
    if (last_of_cloud_i) begin
      phase_d = '0;
      kept_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      kept_q  <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      kept_q  <= kept_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_fire && emit;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: hold the point
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pt_q[0] <= in_x_i;
      pt_q[1] <= in_y_i;
      pt_q[2] <= in_z_i;
      ctl1_q  <= ctl1_d;
    end
  end

  // Stage 2: nine coefficient by coordinate products
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= ProdW'($signed(rot_q[r][CoefW*c +: CoefW]) * pt_q[c]);
        end
      end
      ctl2_q <= ctl1_q;
    end
  end

  // Stage 3: sum the row with the translation and the rounding half
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= AccW'(prod_q[r][0]) + AccW'(prod_q[r][1]) + AccW'(prod_q[r][2])
                  + (AccW'(shift_q[r]) <<< FracBits)
                  + AccW'(1 << (FracBits - 1));
      end
      ctl3_q <= ctl2_q;
    end
  end

  // Stage 4: floor shift and saturate; zero the point when none is carried
  always_comb begin
    logic signed [QuotW-1:0] quot;
    for (int r = 0; r < 3; r++) begin
      quot = acc_q[r][AccW-1:FracBits];
      if (!ctl3_q.present) begin
        res_d[r] = '0;
      end else if (quot > $signed({{(QuotW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}})) begin
        res_d[r] = {1'b0, {(CoordW-1){1'b1}}};
      end else if (quot < $signed({{(QuotW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}})) begin
        res_d[r] = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        res_d[r] = quot[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      res_q  <= res_d;
      ctl4_q <= ctl3_q;
    end
  end

  assign out_valid_o       = v4_q;
  assign out_x_o           = res_q[0];
  assign out_y_o           = res_q[1];
  assign out_z_o           = res_q[2];
  assign point_present_o   = ctl4_q.present;
  assign end_of_cloud_o    = ctl4_q.last;
  assign points_in_cloud_o = ctl4_q.count;

`ifndef NO_ASSERTIONS
  a_word_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (point_present_o || end_of_cloud_o))
    else $error("output word carries neither point nor end marker");

  a_count_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !end_of_cloud_o) |-> (points_in_cloud_o == '0))
    else $error("point count outside an end word");

  a_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KeptCap)
    else $error("kept count above cap");

  a_counters_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_of_cloud_i) |=> (phase_q == '0 && kept_q == '0))
    else $error("counters not cleared after end of cloud");

  a_empty_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !point_present_o) |->
      (out_x_o == '0 && out_y_o == '0 && out_z_o == '0))
    else $error("end word without point has nonzero coordinates");
`endif

endmodule

### sim/point_cloud_decimate_transform_core_tb.sv
// Self-checking testbench for the point cloud decimate and transform core.
module point_cloud_decimate_transform_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcdt_pkg::*;

  localparam int unsigned Latency       = 8;
  localparam int unsigned CycleLimit    = 200_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdlePct       = 21;
  localparam int unsigned RandomRuns    = 13;
  localparam int unsigned RunPoints     = 100;

  // Index 7 is decoded by nothing and must leave every register alone.
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 3'd7;

  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     finite;
    logic                     last;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     present;
    logic                     eoc;
    logic [CountW-1:0]        count;
  } word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [RowW-1:0]    cfg_data_i  = '0;

  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [CoordW-1:0] in_x_i = '0;
  logic signed [CoordW-1:0] in_y_i = '0;
  logic signed [CoordW-1:0] in_z_i = '0;
  logic                     is_finite_i     = 1'b0;
  logic                     last_of_cloud_i = 1'b0;

  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [CoordW-1:0] out_x_o;
  logic signed [CoordW-1:0] out_y_o;
  logic signed [CoordW-1:0] out_z_o;
  logic                     point_present_o;
  logic                     end_of_cloud_o;
  logic [CountW-1:0]        points_in_cloud_o;

  // Mirror of the block's registers and counters
  logic [RowW-1:0]    rot_row [3] = '{RotRow0Reset, RotRow1Reset, RotRow2Reset};
  logic [CoordW-1:0]  trans_vec [3] = '{'0, '0, '0};
  logic [FactorW-1:0] keep_factor = KeepEveryReset;
  int unsigned        phase_pos   = 0;
  int unsigned        kept_points = 0;

  point_t pending_points [$];
  word_t  awaited_words [$];
  point_t offered;

  int unsigned send_idle_pct = IdlePct;
  int unsigned sink_idle_pct = IdlePct;
  int unsigned hold_off_req  = 0;
  int unsigned hold_off_seen = 0;
  int unsigned hold_off_left = 0;
  int unsigned cloud_left    = 0;

  int unsigned points_sent   = 0;
  int unsigned words_seen    = 0;
  int unsigned clouds_closed = 0;
  int unsigned reg_writes    = 0;
  int unsigned errors        = 0;

  point_cloud_decimate_transform_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_x_i           (in_x_i),
    .in_y_i           (in_y_i),
    .in_z_i           (in_z_i),
    .is_finite_i      (is_finite_i),
    .last_of_cloud_i  (last_of_cloud_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_z_o          (out_z_o),
    .point_present_o  (point_present_o),
    .end_of_cloud_o   (end_of_cloud_o),
    .points_in_cloud_o(points_in_cloud_o)
  );

  always #5ns clk_i = ~clk_i;

  // One row of R*p+T: floor after adding half an LSB, then clamp to Q16.16
  function automatic logic signed [CoordW-1:0] map_axis(logic [RowW-1:0] row,
                                                        logic [CoordW-1:0] offset,
                                                        point_t p);
    logic signed [CoordW-1:0] c [3];
    longint acc;
    longint q;
    c = '{p.x, p.y, p.z};
    acc = longint'($signed(offset)) * 64'sd16384;
    for (int j = 0; j < 3; j++) begin
      acc += longint'($signed(row[CoefW*j +: CoefW])) * longint'(c[j]);
    end
    acc += 64'sd8192;
    q = acc >>> FracBits;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
    end
    return CoordW'(q);
  endfunction

  task automatic track_point(input point_t p);
    int unsigned k;
    logic        kept;
    word_t       w;
    k = keep_factor;
    if (k < FactorMin) k = FactorMin;
    if (k > FactorMax) k = FactorMax;
    w = '0;
    kept = (phase_pos == 0) && p.finite;
    if (kept) begin
      w.x = map_axis(rot_row[0], trans_vec[0], p);
      w.y = map_axis(rot_row[1], trans_vec[1], p);
      w.z = map_axis(rot_row[2], trans_vec[2], p);
      w.present = 1'b1;
      if (kept_points < KeptCap) kept_points++;
    end
    phase_pos = (phase_pos + 1 >= k) ? 0 : phase_pos + 1;
    if (p.last) begin
      w.eoc   = 1'b1;
      w.count = CountW'(kept_points);
      phase_pos   = 0;
      kept_points = 0;
      clouds_closed++;
    end
    if (kept || p.last) awaited_words.push_back(w);
  endtask

  function automatic int field_diff(string name, longint want, longint got);
    if (want == got) return 0;
    $display("%t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  // Point driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      track_point(offered);
      points_sent++;
    end
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_points.pop_front();
        in_x_i          <= offered.x;
        in_y_i          <= offered.y;
        in_z_i          <= offered.z;
        is_finite_i     <= offered.finite;
        last_of_cloud_i <= offered.last;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk_i) begin
    word_t want;
    if (out_valid_o && out_ready_i) begin
      words_seen++;
      if (awaited_words.size() == 0) begin
        $display("%t unexpected word: x=%0d y=%0d z=%0d present=%0d end=%0d count=%0d",
                 $time, out_x_o, out_y_o, out_z_o, point_present_o, end_of_cloud_o,
                 points_in_cloud_o);
        errors++;
      end else begin
        want = awaited_words.pop_front();
        errors += field_diff("out_x", want.x, out_x_o);
        errors += field_diff("out_y", want.y, out_y_o);
        errors += field_diff("out_z", want.z, out_z_o);
        errors += field_diff("point_present", want.present, point_present_o);
        errors += field_diff("end_of_cloud", want.eoc, end_of_cloud_o);
        errors += field_diff("points_in_cloud", want.count, points_in_cloud_o);
      end
    end
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen = hold_off_req;
      hold_off_left = HoldOffCycles;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic push_point(input logic signed [CoordW-1:0] x, y, z, input logic fin, lst);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.finite = fin;
    p.last = lst;
    pending_points.push_back(p);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RowW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      CfgRotRow0:   rot_row[0]   = data;
      CfgRotRow1:   rot_row[1]   = data;
      CfgRotRow2:   rot_row[2]   = data;
      CfgShiftX:    trans_vec[0] = data[CoordW-1:0];
      CfgShiftY:    trans_vec[1] = data[CoordW-1:0];
      CfgShiftZ:    trans_vec[2] = data[CoordW-1:0];
      CfgKeepEvery: keep_factor  = data[FactorW-1:0];
      default: ;
    endcase
  endtask

  // Hold until the block has drained, then leave it quiet for a while
  task automatic settle();
    while (pending_points.size() != 0 || in_valid_i || awaited_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (Latency) @(posedge clk_i);
  endtask

  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(3))
      0: return CoefW'($urandom);
      1: return CoefW'(int'($urandom_range(32768)) - 16384);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return CoordW'(int'($urandom_range(2097152)) - 1048576);
      2: return $urandom_range(1) ? CoordMax : CoordMin;
      default: return CoordW'(int'($urandom_range(16)) - 8);
    endcase
  endfunction

  task automatic shuffle_config();
    logic [RowW-1:0] junk;
    if ($urandom_range(1)) write_reg(CfgRotRow0, {rand_coef(), rand_coef(), rand_coef()});
    if ($urandom_range(1)) write_reg(CfgRotRow1, {rand_coef(), rand_coef(), rand_coef()});
    if ($urandom_range(1)) write_reg(CfgRotRow2, {rand_coef(), rand_coef(), rand_coef()});
    if ($urandom_range(1)) write_reg(CfgShiftX, {16'($urandom), rand_coord()});
    if ($urandom_range(1)) write_reg(CfgShiftY, {16'($urandom), rand_coord()});
    if ($urandom_range(1)) write_reg(CfgShiftZ, {16'($urandom), rand_coord()});
    if ($urandom_range(1)) begin
      junk = RowW'({$urandom, $urandom});
      // mostly small factors so kept points stay frequent
      junk[FactorW-1:0] = $urandom_range(4) == 0 ? FactorW'($urandom_range(127))
                                                 : FactorW'($urandom_range(1, 6));
      write_reg(CfgKeepEvery, junk);
    end
  endtask

  task automatic random_points(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (cloud_left == 0) begin
        cloud_left = $urandom_range(7) == 0 ? $urandom_range(1, 200) : $urandom_range(1, 30);
      end
      cloud_left--;
      push_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(9) != 0,
                 cloud_left == 0);
    end
  endtask

  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CycleLimit) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("Timed out after %0d cycles", cycles_run);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: identity, no shift, keep one in four
    push_point(CoordMax, CoordMax, CoordMax, 1'b1, 1'b0);
    push_point(CoordMin, CoordMin, CoordMin, 1'b1, 1'b0);
    push_point(32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
    push_point(-32'sd1, -32'sd1, -32'sd1, 1'b0, 1'b0);
    push_point(CoordMin, CoordMax, 32'sd0, 1'b0, 1'b0);   // kept slot, invalid: drop
    push_point(32'sd5, 32'sd6, 32'sd7, 1'b1, 1'b1);
    push_point(32'sd1, 32'sd2, 32'sd3, 1'b0, 1'b1);       // empty cloud
    push_point(CoordMin, 32'sd0, CoordMax, 1'b1, 1'b1);
    settle();

    // Extreme coefficients and shifts drive both saturation limits
    write_reg(CfgRotRow0, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(CfgRotRow1, {16'h8000, 16'h8000, 16'h8000});
    write_reg(CfgRotRow2, {16'h2000, 16'h0000, 16'h0000});
    write_reg(CfgShiftX, {16'hFFFF, CoordMax});
    write_reg(CfgShiftY, {16'h0000, CoordMin});
    write_reg(CfgShiftZ, '0);
    write_reg(CfgKeepEvery, '0);                          // factor zero acts as one
    push_point(CoordMax, CoordMax, CoordMax, 1'b1, 1'b0);
    push_point(CoordMin, CoordMin, CoordMin, 1'b1, 1'b0);
    push_point(32'sd0, 32'sd0, 32'sd1, 1'b1, 1'b0);       // half way: round up
    push_point(32'sd0, 32'sd0, -32'sd1, 1'b1, 1'b0);
    push_point(32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1);
    settle();

    write_reg(CfgKeepEvery, RowW'(127));                  // beyond the top: acts as 64
    write_reg(CfgUnmapped, RowW'({$urandom, $urandom}));
    push_point(32'sd3, -32'sd3, 32'sd9, 1'b1, 1'b0);
    push_point(32'sd4, -32'sd4, 32'sd8, 1'b1, 1'b0);
    push_point(32'sd5, -32'sd5, 32'sd7, 1'b1, 1'b1);
    settle();

    // Shrink the factor while a cloud is open, phase past the new factor
    write_reg(CfgKeepEvery, RowW'(8));
    for (int i = 0; i < 5; i++) push_point(rand_coord(), rand_coord(), rand_coord(), 1'b1, 1'b0);
    settle();
    write_reg(CfgKeepEvery, RowW'(3));
    for (int i = 0; i < 3; i++) push_point(rand_coord(), rand_coord(), rand_coord(), 1'b1, i == 2);
    settle();
    write_reg(CfgKeepEvery, RowW'(64));
    push_point(32'sd1, 32'sd1, 32'sd1, 1'b1, 1'b1);
    settle();

    for (int unsigned run = 0; run < RandomRuns; run++) begin
      shuffle_config();
      if (run == 3) begin
        // Stall the receiver while points keep coming so the pipe backs up
        write_reg(CfgKeepEvery, RowW'(1));
        send_idle_pct <= 0;
        hold_off_req  <= hold_off_req + 1;
        random_points(150);
        settle();
        send_idle_pct <= IdlePct;
      end else if (run == 7) begin
        send_idle_pct <= 0;
        sink_idle_pct <= 0;
        random_points(RunPoints);
        settle();
        send_idle_pct <= IdlePct;
        sink_idle_pct <= IdlePct;
      end else begin
        random_points(RunPoints);
        settle();
      end
    end

    $display("Run covered %0d points in %0d clouds, %0d register writes, %0d words checked",
             points_sent, clouds_closed, reg_writes, words_seen);
    $display("Settings included extreme rotations and shifts, factors 0 to 127, long stalls");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### point_cloud_decimate_transform_core.f
design/pcdt_pkg.sv
design/point_cloud_decimate_transform_core.sv
sim/point_cloud_decimate_transform_core_tb.sv
